[hdl/pqre_pkg.sv]
`default_nettype none

package pqre_pkg;

    localparam int MAX_RUN_DEF     = 9;
    localparam int COLUMN_BITS_DEF = 16;
    localparam int ROW_WIDTH_BITS  = 16;
    localparam int PAL_SIZE        = 27;
    localparam int Q_DEPTH         = 4;

    localparam logic [7:0]  LETTER_BASE   = 8'd97;
    localparam logic [7:0]  IDLE_SYMBOL   = 8'd126;
    localparam logic [7:0]  DIGIT_ZERO    = 8'd48;
    localparam logic [15:0] ROW_WIDTH_RST = 16'd1;

    // Channel level codes: 0, 127 and 255.
    localparam logic [1:0] LVL_ZERO = 2'd0;
    localparam logic [1:0] LVL_MID  = 2'd1;
    localparam logic [1:0] LVL_FULL = 2'd2;

    typedef struct packed {
        logic [1:0] r;
        logic [1:0] g;
        logic [1:0] b;
    } t_levels;

    typedef struct packed {
        logic [1:0] code;
        logic       tie;
    } t_chan_level;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
    } t_item;

    localparam t_levels PALETTE [PAL_SIZE] = '{
        '{LVL_ZERO, LVL_ZERO, LVL_ZERO}, '{LVL_ZERO, LVL_ZERO, LVL_MID},
        '{LVL_ZERO, LVL_ZERO, LVL_FULL}, '{LVL_ZERO, LVL_MID,  LVL_ZERO},
        '{LVL_ZERO, LVL_MID,  LVL_MID},  '{LVL_ZERO, LVL_MID,  LVL_FULL},
        '{LVL_ZERO, LVL_FULL, LVL_ZERO}, '{LVL_ZERO, LVL_FULL, LVL_MID},
        '{LVL_ZERO, LVL_FULL, LVL_FULL}, '{LVL_MID,  LVL_MID,  LVL_MID},
        '{LVL_MID,  LVL_MID,  LVL_ZERO}, '{LVL_MID,  LVL_MID,  LVL_FULL},
        '{LVL_MID,  LVL_ZERO, LVL_ZERO}, '{LVL_MID,  LVL_ZERO, LVL_MID},
        '{LVL_MID,  LVL_ZERO, LVL_FULL}, '{LVL_MID,  LVL_FULL, LVL_ZERO},
        '{LVL_MID,  LVL_FULL, LVL_MID},  '{LVL_MID,  LVL_FULL, LVL_FULL},
        '{LVL_FULL, LVL_FULL, LVL_FULL}, '{LVL_FULL, LVL_FULL, LVL_ZERO},
        '{LVL_FULL, LVL_FULL, LVL_MID},  '{LVL_FULL, LVL_ZERO, LVL_ZERO},
        '{LVL_FULL, LVL_ZERO, LVL_MID},  '{LVL_FULL, LVL_ZERO, LVL_FULL},
        '{LVL_FULL, LVL_MID,  LVL_ZERO}, '{LVL_FULL, LVL_MID,  LVL_MID},
        '{LVL_FULL, LVL_MID,  LVL_FULL}
    };

    // The distance is separable per channel, so the nearest level of each
    // channel gives the nearest colour. Only 191 is equidistant (127 and 255).
    function automatic t_chan_level chan_level(input logic [7:0] v);
        t_chan_level res;
        res.tie = 1'b0;
        if (v < 8'd64) begin
            res.code = LVL_ZERO;
        end else if (v < 8'd191) begin
            res.code = LVL_MID;
        end else if (v == 8'd191) begin
            res.code = LVL_MID;
            res.tie  = 1'b1;
        end else begin
            res.code = LVL_FULL;
        end
        return res;
    endfunction

    function automatic logic [4:0] pal_lookup(input t_levels lv);
        logic [4:0] idx;
        idx = 5'd0;
        for (int i = PAL_SIZE - 1; i >= 0; i--) begin
            if (PALETTE[i] == lv) begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

[hdl/pqre_pixel_if.sv]
`default_nettype none

interface pqre_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

[hdl/pqre_symbol_if.sv]
`default_nettype none

interface pqre_symbol_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       last_of_run;

    modport source (output valid, output symbol, output last_of_run, input ready);
    modport sink (input valid, input symbol, input last_of_run, output ready);
endinterface

`default_nettype wire

[hdl/palette_quantize_rle_encoder.sv]
`default_nettype none

// Maps each RGB pixel to the nearest of 27 palette colours (letters a to {)
// and codes runs of equal letters within a row as the letter followed by one
// count digit, a longer run being split at MAX_RUN. A pixel transaction is
// accepted in every cycle that the four-entry queue between the classifier
// and the run coder has room; the coder then delivers one symbol per cycle
// while o_sym.ready is high, and a pixel gives up to three symbols. A pixel
// that only extends a run leaves the queue and delivers nothing. row_width is
// written through i_cfg_we and i_cfg_wdata; the user must write it only while
// the block is idle, which the block does not enforce; zero acts as one.

module palette_quantize_rle_encoder
    import pqre_pkg::*;
#(
    parameter int MAX_RUN     = MAX_RUN_DEF,
    parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [ROW_WIDTH_BITS-1:0] i_cfg_wdata,
    pqre_pixel_if.sink                     i_pix,
    pqre_symbol_if.source                  o_sym
);

    t_item w_push_item;
    t_item w_head_item;
    logic  w_push;
    logic  w_pop;
    logic  w_full;
    logic  w_head_valid;

    pqre_front #(
        .COLUMN_BITS (COLUMN_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pix       (i_pix),
        .i_q_full    (w_full),
        .o_q_item    (w_push_item),
        .o_q_push    (w_push)
    );

    pqre_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_head_valid),
        .o_item  (w_head_item)
    );

    pqre_back #(
        .MAX_RUN (MAX_RUN)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_head_valid),
        .i_q_item  (w_head_item),
        .o_q_pop   (w_pop),
        .o_sym     (o_sym)
    );

endmodule

`default_nettype wire

[hdl/pqre_front.sv]
`default_nettype none

module pqre_front
    import pqre_pkg::*;
#(
    parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [ROW_WIDTH_BITS-1:0] i_cfg_wdata,
    pqre_pixel_if.sink                     i_pix,
    input  wire logic                      i_q_full,
    output t_item                          o_q_item,
    output logic                           o_q_push
);

    localparam int CMP_W = (COLUMN_BITS > ROW_WIDTH_BITS) ? COLUMN_BITS : ROW_WIDTH_BITS;

    logic [ROW_WIDTH_BITS-1:0] r_row_width;
    logic [COLUMN_BITS-1:0]    r_col;
    logic [COLUMN_BITS-1:0]    n_col;
    logic [ROW_WIDTH_BITS-1:0] w_last_col;
    logic                      w_last;
    t_chan_level               w_lr;
    t_chan_level               w_lg;
    t_chan_level               w_lb;
    logic [4:0]                w_idx;

    assign i_pix.ready = !i_q_full;
    assign o_q_push    = i_pix.valid && !i_q_full;

    assign w_last_col = (r_row_width == '0) ? '0 : r_row_width - 1'b1;
    assign w_last     = CMP_W'(r_col) >= CMP_W'(w_last_col);
    assign n_col      = w_last ? '0 : r_col + 1'b1;

    assign w_lr = chan_level(i_pix.red);
    assign w_lg = chan_level(i_pix.green);
    assign w_lb = chan_level(i_pix.blue);

    // Where a channel sits exactly between two levels, every combination is
    // tried and the lowest palette index is kept.
    always_comb begin
        t_levels    cand;
        logic [4:0] idx;
        w_idx = 5'(PAL_SIZE - 1);
        for (int k = 0; k < 8; k++) begin
            cand.r = (k[2] && w_lr.tie) ? LVL_FULL : w_lr.code;
            cand.g = (k[1] && w_lg.tie) ? LVL_FULL : w_lg.code;
            cand.b = (k[0] && w_lb.tie) ? LVL_FULL : w_lb.code;
            idx    = pal_lookup(cand);
            if (idx < w_idx) begin
                w_idx = idx;
            end
        end
    end

    assign o_q_item.symbol = LETTER_BASE + {3'b000, w_idx};
    assign o_q_item.last   = w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= ROW_WIDTH_RST;
            r_col       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_row_width <= i_cfg_wdata;
            end
            if (o_q_push) begin
                r_col <= n_col;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/pqre_fifo.sv]
`default_nettype none

module pqre_fifo
    import pqre_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_valid,
    output t_item      o_item
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_item              r_mem [Q_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = r_count == CNT_W'(Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

[hdl/pqre_back.sv]
`default_nettype none

module pqre_back
    import pqre_pkg::*;
#(
    parameter int MAX_RUN = MAX_RUN_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_q_valid,
    input  wire t_item   i_q_item,
    output logic         o_q_pop,
    pqre_symbol_if.source o_sym
);

    localparam logic [3:0] MAX_RUN_C = 4'(MAX_RUN);

    logic [7:0] r_cur;
    logic [3:0] r_cnt;
    logic [1:0] r_step;
    logic       r_valid;
    logic [7:0] r_symbol;
    logic       r_last;

    logic [7:0] w_slot [4];
    logic [1:0] w_n;
    logic [7:0] n_cur;
    logic [3:0] n_cnt;
    logic       w_emit_ok;
    logic       w_load;
    logic       w_final;

    // Builds the list of symbols the head item gives, from the run state as
    // it stands before the item.
    always_comb begin
        logic [3:0] cnt1;
        cnt1      = r_cnt + 4'd1;
        w_n       = 2'd0;
        n_cur     = r_cur;
        n_cnt     = cnt1;
        for (int k = 0; k < 4; k++) begin
            w_slot[k] = DIGIT_ZERO;
        end
        if (i_q_item.symbol == r_cur) begin
            if (cnt1 > MAX_RUN_C) begin
                w_slot[w_n] = DIGIT_ZERO + {4'b0000, MAX_RUN_C};
                w_n         = w_n + 2'd1;
                w_slot[w_n] = r_cur;
                w_n         = w_n + 2'd1;
                n_cnt       = 4'd1;
                if (i_q_item.last) begin
                    w_slot[w_n] = DIGIT_ZERO + 8'd1;
                    w_n         = w_n + 2'd1;
                end
            end else if (i_q_item.last) begin
                w_slot[w_n] = DIGIT_ZERO + {4'b0000, cnt1};
                w_n         = w_n + 2'd1;
            end
        end else begin
            if (r_cnt != 4'd0) begin
                w_slot[w_n] = DIGIT_ZERO + {4'b0000, r_cnt};
                w_n         = w_n + 2'd1;
            end
            w_slot[w_n] = i_q_item.symbol;
            w_n         = w_n + 2'd1;
            n_cur       = i_q_item.symbol;
            n_cnt       = 4'd1;
            if (i_q_item.last) begin
                w_slot[w_n] = DIGIT_ZERO + 8'd1;
                w_n         = w_n + 2'd1;
            end
        end
        if (i_q_item.last) begin
            n_cur = IDLE_SYMBOL;
            n_cnt = 4'd0;
        end
    end

    assign w_emit_ok = !r_valid || o_sym.ready;
    assign w_final   = r_step == (w_n - 2'd1);
    assign w_load    = i_q_valid && (w_n != 2'd0) && w_emit_ok;
    assign o_q_pop   = i_q_valid && ((w_n == 2'd0) || (w_emit_ok && w_final));

    assign o_sym.valid       = r_valid;
    assign o_sym.symbol      = r_symbol;
    assign o_sym.last_of_run = r_last;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_symbol <= w_slot[r_step];
            r_last   <= w_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= IDLE_SYMBOL;
            r_cnt   <= 4'd0;
            r_step  <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (o_sym.ready) begin
                r_valid <= 1'b0;
            end
            if (o_q_pop) begin
                r_cur  <= n_cur;
                r_cnt  <= n_cnt;
                r_step <= 2'd0;
            end else if (w_load) begin
                r_step <= r_step + 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

[test/palette_quantize_rle_encoder_tb.sv]
module palette_quantize_rle_encoder_tb
    import pqre_pkg::*;
;

    localparam int RUN_LIMIT   = MAX_RUN_DEF;
    localparam int DRAIN_WAIT  = 20;
    localparam int STALL_LIMIT = 3000;
    localparam int IDLE_PCT    = 20;

    localparam logic [23:0] PAL_RGB [PAL_SIZE] = '{
        24'h000000, 24'h00007F, 24'h0000FF, 24'h007F00, 24'h007F7F, 24'h007FFF,
        24'h00FF00, 24'h00FF7F, 24'h00FFFF, 24'h7F7F7F, 24'h7F7F00, 24'h7F7FFF,
        24'h7F0000, 24'h7F007F, 24'h7F00FF, 24'h7FFF00, 24'h7FFF7F, 24'h7FFFFF,
        24'hFFFFFF, 24'hFFFF00, 24'hFFFF7F, 24'hFF0000, 24'hFF007F, 24'hFF00FF,
        24'hFF7F00, 24'hFF7F7F, 24'hFF7FFF
    };

    class rle_scoreboard;
        logic [15:0] row_width;
        logic [7:0]  cur_symbol;
        int          run_len;
        logic [15:0] col_idx;
        t_item       expected_symbols[$];
        int          errors;

        function new();
            row_width  = ROW_WIDTH_RST;
            cur_symbol = IDLE_SYMBOL;
            run_len    = 0;
            col_idx    = '0;
            errors     = 0;
        endfunction

        task report(input string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        function int nearest_colour(input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b);
            int best;
            int best_dist;
            int sq_dist;
            int dr;
            int dg;
            int db;
            best      = 0;
            best_dist = 32'h7FFFFFFF;
            for (int i = 0; i < PAL_SIZE; i++) begin
                dr      = int'(r) - int'(PAL_RGB[i][23:16]);
                dg      = int'(g) - int'(PAL_RGB[i][15:8]);
                db      = int'(b) - int'(PAL_RGB[i][7:0]);
                sq_dist = dr * dr + dg * dg + db * db;
                if (sq_dist < best_dist) begin
                    best_dist = sq_dist;
                    best      = i;
                end
            end
            return best;
        endfunction

        function void note_pixel(input logic [7:0] r, input logic [7:0] g,
                                 input logic [7:0] b);
            logic [7:0]  letter;
            logic [16:0] eff_width;
            logic        row_end;
            logic [7:0]  out_syms[$];
            t_item       item;
            letter    = LETTER_BASE + 8'(nearest_colour(r, g, b));
            eff_width = (row_width == 16'd0) ? 17'd1 : {1'b0, row_width};
            row_end   = {1'b0, col_idx} >= eff_width - 17'd1;
            if (letter == cur_symbol) begin
                run_len++;
                if (run_len > RUN_LIMIT) begin
                    out_syms.push_back(DIGIT_ZERO + 8'(RUN_LIMIT));
                    out_syms.push_back(cur_symbol);
                    run_len = 1;
                    if (row_end) begin
                        out_syms.push_back(DIGIT_ZERO + 8'd1);
                    end
                end else if (row_end) begin
                    out_syms.push_back(DIGIT_ZERO + 8'(run_len));
                end
            end else begin
                if (run_len > 0) begin
                    out_syms.push_back(DIGIT_ZERO + 8'(run_len));
                end
                cur_symbol = letter;
                out_syms.push_back(letter);
                run_len = 1;
                if (row_end) begin
                    out_syms.push_back(DIGIT_ZERO + 8'd1);
                end
            end
            foreach (out_syms[i]) begin
                item.symbol = out_syms[i];
                item.last   = (i == out_syms.size() - 1);
                expected_symbols.push_back(item);
            end
            if (row_end) begin
                cur_symbol = IDLE_SYMBOL;
                run_len    = 0;
                col_idx    = '0;
            end else begin
                col_idx = col_idx + 16'd1;
            end
        endfunction

        task check_symbol(input logic [7:0] got_symbol, input logic got_last);
            t_item want;
            if (expected_symbols.size() == 0) begin
                report($sformatf("symbol %0d arrived with nothing expected", got_symbol));
                return;
            end
            want = expected_symbols.pop_front();
            if (want.symbol !== got_symbol) begin
                report($sformatf("symbol %0d, expected %0d", got_symbol, want.symbol));
            end
            if (want.last !== got_last) begin
                report($sformatf("last_of_run %0b on symbol %0d, expected %0b",
                                 got_last, got_symbol, want.last));
            end
        endtask

        task check_drained();
            if (expected_symbols.size() != 0) begin
                report($sformatf("%0d expected symbols never arrived",
                                 expected_symbols.size()));
            end
        endtask
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [ROW_WIDTH_BITS-1:0] i_cfg_wdata;
    logic                      calm;
    int                        quiet_cycles;
    rle_scoreboard             sb;

    pqre_pixel_if  pixel_bus ();
    pqre_symbol_if symbol_bus ();

    palette_quantize_rle_encoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pix       (pixel_bus),
        .o_sym       (symbol_bus)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    always @(negedge i_clk) begin
        symbol_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && symbol_bus.valid && symbol_bus.ready) begin
            sb.check_symbol(symbol_bus.symbol, symbol_bus.last_of_run);
        end
    end

    function automatic logic [7:0] level_value(input int level);
        case (level)
            0: begin
                return 8'($urandom_range(0, 63));
            end
            1: begin
                return 8'($urandom_range(64, 191));
            end
            default: begin
                return 8'($urandom_range(192, 255));
            end
        endcase
    endfunction

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            pixel_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        pixel_bus.valid <= 1'b1;
        pixel_bus.red   <= r;
        pixel_bus.green <= g;
        pixel_bus.blue  <= b;
        @(posedge i_clk);
        while (!pixel_bus.ready) begin
            @(posedge i_clk);
        end
        sb.note_pixel(r, g, b);
        @(negedge i_clk);
    endtask

    task automatic drain();
        pixel_bus.valid <= 1'b0;
        while (sb.expected_symbols.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_width(input logic [15:0] width);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= width;
        sb.row_width = width;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_runs(input int n_items);
        int sent;
        int len;
        int lr;
        int lg;
        int lb;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 15) begin
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
                sent++;
            end else begin
                lr  = $urandom_range(0, 2);
                lg  = $urandom_range(0, 2);
                lb  = $urandom_range(0, 2);
                len = $urandom_range(1, 13);
                if (len > n_items - sent) begin
                    len = n_items - sent;
                end
                repeat (len) begin
                    send_pixel(level_value(lr), level_value(lg), level_value(lb));
                    sent++;
                end
            end
        end
    endtask

    initial begin : watchdog
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((pixel_bus.valid && pixel_bus.ready) ||
                (symbol_bus.valid && symbol_bus.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("palette_quantize_rle_encoder_tb: errors");
        $finish;
    end

    initial begin : stimulus
        logic [15:0] widths [8];
        widths = '{16'd1, 16'd7, 16'd16, 16'd65535, 16'd3, 16'd9, 16'd10, 16'd5};
        sb               = new();
        calm             = 1'b0;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        pixel_bus.valid  = 1'b0;
        pixel_bus.red    = '0;
        pixel_bus.green  = '0;
        pixel_bus.blue   = '0;
        symbol_bus.ready = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // A zero width behaves as one, so each pixel closes its own row.
        write_width(16'd0);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd191, 8'd191, 8'd191);
        drain();

        // The run splits exactly on the last column of the row.
        write_width(16'd10);
        repeat (10) send_pixel(8'd200, 8'd100, 8'd30);
        drain();

        write_width(16'd65535);
        send_pixel(8'd63, 8'd64, 8'd190);
        send_pixel(8'd64, 8'd63, 8'd192);
        send_pixel(8'd190, 8'd192, 8'd64);
        send_pixel(8'd192, 8'd190, 8'd63);
        send_pixel(8'd127, 8'd127, 8'd127);
        send_pixel(8'd128, 8'd126, 8'd127);
        drain();

        // Narrowing the row mid-way ends it on the next pixel.
        write_width(16'd12);
        repeat (4) send_pixel(8'd0, 8'd255, 8'd0);
        drain();
        write_width(16'd2);
        send_pixel(8'd0, 8'd255, 8'd0);
        drain();

        foreach (widths[i]) begin
            write_width(widths[i]);
            calm = (i == 2);
            if (i == 5) begin
                send_runs(13);
                drain();
                send_runs(13);
            end else begin
                send_runs(26);
            end
            drain();
        end
        calm = 1'b0;

        sb.check_drained();
        if (sb.errors == 0) begin
            $display("palette_quantize_rle_encoder_tb: clean");
        end else begin
            $display("palette_quantize_rle_encoder_tb: errors");
        end
        $finish;
    end

endmodule

[palette_quantize_rle_encoder.f]
hdl/pqre_pkg.sv
hdl/pqre_pixel_if.sv
hdl/pqre_symbol_if.sv
hdl/pqre_front.sv
hdl/pqre_fifo.sv
hdl/pqre_back.sv
hdl/palette_quantize_rle_encoder.sv
test/palette_quantize_rle_encoder_tb.sv
